/* sv/assert_macros.svh */
// assertion helpers included by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is held
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// clocked implication, disabled while reset is held
`define ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/calc_tiu_pkg.sv */
`default_nettype none

package calc_tiu_pkg;

    // register file geometry
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CONTROL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_RELOAD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_CONTROL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_CONTROL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HW_GENERATION = 3'd4;

    // timer control bits
    localparam int unsigned TC_OSC_EN  = 1;
    localparam int unsigned TC_INT3_EN = 2;
    localparam int unsigned TC_TMR_EN  = 3;
    localparam int unsigned TC_MASK    = 7;

    // link control bits
    localparam int unsigned LC_RXF_EN  = 0;
    localparam int unsigned LC_TXE_EN  = 1;
    localparam int unsigned LC_ACT_EN  = 2;
    localparam int unsigned LC_ERR_EN  = 3;
    localparam int unsigned LC_INT_DIS = 6;

    // power control bits
    localparam int unsigned PC_GATE_LO = 1;
    localparam int unsigned PC_GATE_HI = 2;

    // counter widths
    localparam int unsigned TICK_W  = 4;
    localparam int unsigned TIMER_W = 8;
    localparam int unsigned HB_W    = 11;

    localparam int unsigned HEARTBEAT_PERIOD_DEF = 1024;

    // one result item
    typedef struct packed {
        logic raise_int1;
        logic raise_int3;
        logic raise_int4;
        logic raise_int5;
        logic set_link_activity;
        logic keyboard_scan;
        logic lcd_refresh;
    } result_t;

endpackage

`default_nettype wire

/* sv/calculator_asic_tick_interrupt_unit_core.sv */
// Tick and interrupt unit. Each transfer on the input channel is one oscillator
// tick carrying the link status bits and wire levels; each tick yields exactly one
// result transfer with the interrupt requests and the keyboard and LCD pulses.
// A tick is taken every cycle while in_stall is low; its result goes to the single
// result register, or first to the skid stage when stalled. A one-entry skid stage
// behind that register keeps ticks flowing while the output is stalled; in_stall
// rises only when both are full. Configuration is written through cfg_write,
// cfg_index and cfg_data with no wait; indexes past the last register are ignored.
// The heartbeat reload value is set by HEARTBEAT_PERIOD (2 to 2048, taken mod 2048).
`default_nettype none

`include "assert_macros.svh"

module calculator_asic_tick_interrupt_unit_core
    import calc_tiu_pkg::*;
#(
    parameter int unsigned HEARTBEAT_PERIOD = HEARTBEAT_PERIOD_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // tick channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  link_error,
    input  wire logic                  tx_buffer_empty,
    input  wire logic                  rx_buffer_full,
    input  wire logic                  link_activity_flag,
    input  wire logic                  red_wire_level,
    input  wire logic                  white_wire_level,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       raise_int1,
    output logic                       raise_int3,
    output logic                       raise_int4,
    output logic                       raise_int5,
    output logic                       set_link_activity,
    output logic                       keyboard_scan,
    output logic                       lcd_refresh
);

    localparam logic [HB_W-1:0] HB_RELOAD = HB_W'(HEARTBEAT_PERIOD);

    // configuration registers
    logic [7:0] timer_control_reg;
    logic [7:0] timer_reload_reg;
    logic [7:0] link_control_reg;
    logic [7:0] power_control_reg;
    logic       hw_generation_reg;

    // counters
    logic [TICK_W-1:0]  tick_reg,  tick_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [HB_W-1:0]    hb_reg,    hb_next;

    // output register and skid stage
    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;

    result_t res;
    logic    accept;
    logic    out_free;

    logic [TICK_W-1:0]  tick_step;
    logic [TIMER_W-1:0] timer_step;
    logic [HB_W-1:0]    hb_step;
    logic               gate;
    logic               act;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_control_reg <= '0;
            timer_reload_reg  <= '0;
            link_control_reg  <= '0;
            power_control_reg <= '0;
            hw_generation_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TIMER_CONTROL: timer_control_reg <= cfg_data;
                REG_TIMER_RELOAD:  timer_reload_reg  <= cfg_data;
                REG_LINK_CONTROL:  link_control_reg  <= cfg_data;
                REG_POWER_CONTROL: power_control_reg <= cfg_data;
                REG_HW_GENERATION: hw_generation_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // tick evaluation
    always_comb
    begin
        res        = '0;
        tick_next  = tick_reg;
        timer_next = timer_reg;
        hb_next    = hb_reg;
        tick_step  = tick_reg;
        timer_step = timer_reg;
        hb_step    = hb_reg;
        gate       = 1'b0;
        act        = 1'b0;

        if (!timer_control_reg[TC_OSC_EN])
        begin
            res.keyboard_scan = 1'b1;
        end
        else
        begin
            // counters step only with the timer enabled; the zero reloads below still apply
            if (timer_control_reg[TC_TMR_EN])
            begin
                timer_step = (timer_reg != '0) ? timer_reg + 1'b1 : timer_reload_reg;
                tick_step  = tick_reg + 1'b1;
                hb_step    = hb_reg - 1'b1;
            end

            gate = !timer_control_reg[TC_MASK] &&
                   (!(power_control_reg[PC_GATE_HI] && !power_control_reg[PC_GATE_LO]) ||
                    !hw_generation_reg);

            res.raise_int1 = (tick_step[1:0] == 2'b00) && gate;

            // heartbeat reaching zero reloads the period
            hb_next = hb_step;
            if (hb_step == '0)
            begin
                hb_next        = HB_RELOAD;
                res.raise_int3 = gate && timer_control_reg[TC_INT3_EN];
            end

            // link activity and link interrupt
            res.set_link_activity = !red_wire_level || !white_wire_level;
            act = link_activity_flag || res.set_link_activity;
            res.raise_int4 = !link_control_reg[LC_INT_DIS] &&
                             ((link_control_reg[LC_ERR_EN] && link_error) ||
                              (link_control_reg[LC_ACT_EN] && act) ||
                              (link_control_reg[LC_TXE_EN] && tx_buffer_empty) ||
                              (link_control_reg[LC_RXF_EN] && rx_buffer_full));

            // programmable timer wrap
            timer_next = timer_step;
            if (timer_step == '0)
            begin
                timer_next     = timer_reload_reg - 1'b1;
                res.raise_int5 = gate;
            end

            res.keyboard_scan = (tick_step[2:0] == 3'b000);
            res.lcd_refresh   = !hw_generation_reg && (tick_step == '0);
            tick_next         = tick_step;
        end
    end

    // counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            timer_reg <= '0;
            hb_reg    <= HB_RELOAD;
        end
        else if (accept)
        begin
            tick_reg  <= tick_next;
            timer_reg <= timer_next;
            hb_reg    <= hb_next;
        end
    end

    // result register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign raise_int1        = out_reg.raise_int1;
    assign raise_int3        = out_reg.raise_int3;
    assign raise_int4        = out_reg.raise_int4;
    assign raise_int5        = out_reg.raise_int5;
    assign set_link_activity = out_reg.set_link_activity;
    assign keyboard_scan     = out_reg.keyboard_scan;
    assign lcd_refresh       = out_reg.lcd_refresh;

    // checks
    `ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry held without a result in the output register")
    `ASSERT_IMPLY(a_osc_stop_holds, clk, rst_n,
        accept && !timer_control_reg[TC_OSC_EN],
        ##1 ($stable(tick_reg) && $stable(timer_reg) && $stable(hb_reg)),
        "counters moved on a tick with the oscillator stopped")
    `ASSERT_CLK(a_skid_fill_on_stall, clk, rst_n,
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall),
        "skid filled while the output register was free")

endmodule

`default_nettype wire
